// ===== design/sams_pkg.sv =====
package sams_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 24'd20000;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST     = 32'd10000;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_MOVE_REL    = 3'd1,
    REQ_MOVE_ABS    = 3'd2,
    REQ_STOP        = 3'd3,
    REQ_ENABLE      = 3'd4,
    REQ_DISABLE     = 3'd5,
    REQ_CLEAR_FAULT = 3'd6
  } req_code_t;

  typedef enum logic [2:0] {
    RC_OK          = 3'd0,
    RC_INVALID     = 3'd1,
    RC_NOT_ENABLED = 3'd2,
    RC_FAULT       = 3'd3,
    RC_BUSY        = 3'd4
  } result_code_t;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_IDLE     = 3'd1,
    ST_MOVING   = 3'd2,
    ST_STOPPING = 3'd3,
    ST_DONE     = 3'd4,
    ST_ERROR    = 3'd5
  } axis_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [POS_W-1:0]   step_amount;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  now_ms;
    logic [POS_W-1:0]   hw_step_count;
    logic               driver_busy;
  } item_t;

  typedef struct packed {
    result_code_t       result_code;
    axis_state_t        axis_state;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   target_position;
    logic               fault_flag;
    logic               err_timeout;
    logic               start_move;
    logic               move_ccw;
    logic [POS_W-1:0]   move_magnitude;
    logic [SPEED_W-1:0] move_speed;
    logic               stop_request;
    logic               driver_on;
  } result_t;

endpackage

// ===== design/sams_req_if.sv =====
interface sams_req_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         req_type;
  logic signed [sams_pkg::POS_W-1:0]  step_amount;
  logic [sams_pkg::SPEED_W-1:0]       speed;
  logic [sams_pkg::TIME_W-1:0]        now_ms;
  logic [sams_pkg::POS_W-1:0]         hw_step_count;
  logic                               driver_busy;

  modport source (
    output valid, req_type, step_amount, speed, now_ms, hw_step_count, driver_busy,
    input  ready
  );
  modport sink (
    input  valid, req_type, step_amount, speed, now_ms, hw_step_count, driver_busy,
    output ready
  );
endinterface

// ===== design/sams_res_if.sv =====
interface sams_res_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         result_code;
  logic [2:0]                         axis_state;
  logic signed [sams_pkg::POS_W-1:0]  position;
  logic signed [sams_pkg::POS_W-1:0]  target_position;
  logic                               fault_flag;
  logic                               err_timeout;
  logic                               start_move;
  logic                               move_ccw;
  logic [sams_pkg::POS_W-1:0]         move_magnitude;
  logic [sams_pkg::SPEED_W-1:0]       move_speed;
  logic                               stop_request;
  logic                               driver_on;

  modport source (
    output valid, result_code, axis_state, position, target_position, fault_flag,
           err_timeout, start_move, move_ccw, move_magnitude, move_speed,
           stop_request, driver_on,
    input  ready
  );
  modport sink (
    input  valid, result_code, axis_state, position, target_position, fault_flag,
           err_timeout, start_move, move_ccw, move_magnitude, move_speed,
           stop_request, driver_on,
    output ready
  );
endinterface

// ===== design/sams_cfg_if.sv =====
interface sams_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sams_pkg::CFG_IDX_W-1:0]      index;
  logic [sams_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sams_axis_core.sv =====
module sams_axis_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  sams_pkg::item_t               item,
  input  logic [sams_pkg::SPEED_W-1:0]  speed_limit,
  input  logic [sams_pkg::TIME_W-1:0]   timeout_limit,
  output sams_pkg::result_t             result
);

  sams_pkg::axis_state_t          mode_state, mode_state_next;
  logic                           enabled_flag, enabled_flag_next;
  logic                           fault_latch, fault_latch_next;
  logic                           error_record, error_record_next;
  logic [sams_pkg::POS_W-1:0]     cur_pos, cur_pos_next;
  logic [sams_pkg::POS_W-1:0]     tgt_pos, tgt_pos_next;
  logic [sams_pkg::POS_W-1:0]     start_pos, start_pos_next;
  logic [sams_pkg::POS_W-1:0]     start_hw_count, start_hw_count_next;
  logic                           dir_negative, dir_negative_next;
  logic [sams_pkg::SPEED_W-1:0]   saved_speed, saved_speed_next;
  logic [sams_pkg::TIME_W-1:0]    start_time, start_time_next;

  logic [sams_pkg::POS_W-1:0]     delta;
  logic [sams_pkg::POS_W-1:0]     tracked;
  logic [sams_pkg::POS_W-1:0]     steps;
  logic [sams_pkg::TIME_W-1:0]    elapsed;
  logic                           active;
  sams_pkg::result_code_t         rc;
  logic                           start;
  logic                           ccw;
  logic [sams_pkg::POS_W-1:0]     mag;
  logic                           stop;

  assign delta   = item.hw_step_count - start_hw_count;
  assign tracked = dir_negative ? (start_pos - delta) : (start_pos + delta);
  assign steps   = (item.req_type == sams_pkg::REQ_MOVE_REL) ? item.step_amount
                                                             : (item.step_amount - cur_pos);
  assign elapsed = item.now_ms - start_time;
  assign active  = (mode_state == sams_pkg::ST_MOVING) || (mode_state == sams_pkg::ST_STOPPING);

  always_comb begin
    mode_state_next     = mode_state;
    enabled_flag_next   = enabled_flag;
    fault_latch_next    = fault_latch;
    error_record_next   = error_record;
    cur_pos_next        = cur_pos;
    tgt_pos_next        = tgt_pos;
    start_pos_next      = start_pos;
    start_hw_count_next = start_hw_count;
    dir_negative_next   = dir_negative;
    saved_speed_next    = saved_speed;
    start_time_next     = start_time;
    rc    = sams_pkg::RC_OK;
    start = 1'b0;
    ccw   = 1'b0;
    mag   = '0;
    stop  = 1'b0;
    unique case (sams_pkg::req_code_t'(item.req_type))
      sams_pkg::REQ_TICK: begin
        if (active) begin
          cur_pos_next = tracked;
          if (mode_state == sams_pkg::ST_STOPPING) begin
            if (!item.driver_busy) mode_state_next = sams_pkg::ST_IDLE;
          end else if ((timeout_limit != '0) && (elapsed > timeout_limit)) begin
            stop              = 1'b1;
            fault_latch_next  = 1'b1;
            error_record_next = 1'b1;
            mode_state_next   = sams_pkg::ST_ERROR;
          end else if (!item.driver_busy) begin
            cur_pos_next    = tgt_pos;
            mode_state_next = sams_pkg::ST_DONE;
          end
        end
      end
      sams_pkg::REQ_MOVE_REL, sams_pkg::REQ_MOVE_ABS: begin
        if ((steps == '0) || (item.speed == '0) || (item.speed > speed_limit)) begin
          rc = sams_pkg::RC_INVALID;
        end else if (!enabled_flag) begin
          rc = sams_pkg::RC_NOT_ENABLED;
        end else if (fault_latch) begin
          rc = sams_pkg::RC_FAULT;
        end else if (active) begin
          rc = sams_pkg::RC_BUSY;
        end else begin
          ccw                 = !steps[sams_pkg::POS_W-1];
          mag                 = steps[sams_pkg::POS_W-1] ? ('0 - steps) : steps;
          dir_negative_next   = steps[sams_pkg::POS_W-1];
          start_pos_next      = cur_pos;
          start_hw_count_next = item.hw_step_count;
          tgt_pos_next        = cur_pos + steps;
          saved_speed_next    = item.speed;
          start_time_next     = item.now_ms;
          error_record_next   = 1'b0;
          start               = 1'b1;
          mode_state_next     = sams_pkg::ST_MOVING;
        end
      end
      sams_pkg::REQ_STOP: begin
        if (mode_state == sams_pkg::ST_MOVING) begin
          mode_state_next = sams_pkg::ST_STOPPING;
          stop            = 1'b1;
          cur_pos_next    = tracked;
        end
      end
      sams_pkg::REQ_ENABLE: begin
        if (fault_latch) begin
          rc = sams_pkg::RC_FAULT;
        end else begin
          enabled_flag_next = 1'b1;
          if (mode_state == sams_pkg::ST_DISABLED) mode_state_next = sams_pkg::ST_IDLE;
        end
      end
      sams_pkg::REQ_DISABLE: begin
        stop              = 1'b1;
        enabled_flag_next = 1'b0;
        mode_state_next   = sams_pkg::ST_DISABLED;
      end
      sams_pkg::REQ_CLEAR_FAULT: begin
        if (mode_state == sams_pkg::ST_ERROR) begin
          fault_latch_next  = 1'b0;
          error_record_next = 1'b0;
          mode_state_next   = enabled_flag ? sams_pkg::ST_IDLE : sams_pkg::ST_DISABLED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.result_code     = rc;
    result.axis_state      = mode_state_next;
    result.position        = cur_pos_next;
    result.target_position = tgt_pos_next;
    result.fault_flag      = fault_latch_next;
    result.err_timeout     = error_record_next;
    result.start_move      = start;
    result.move_ccw        = ccw;
    result.move_magnitude  = mag;
    result.move_speed      = saved_speed_next;
    result.stop_request    = stop;
    result.driver_on       = enabled_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state     <= sams_pkg::ST_DISABLED;
      enabled_flag   <= 1'b0;
      fault_latch    <= 1'b0;
      error_record   <= 1'b0;
      cur_pos        <= '0;
      tgt_pos        <= '0;
      start_pos      <= '0;
      start_hw_count <= '0;
      dir_negative   <= 1'b0;
      saved_speed    <= '0;
      start_time     <= '0;
    end else if (step) begin
      mode_state     <= mode_state_next;
      enabled_flag   <= enabled_flag_next;
      fault_latch    <= fault_latch_next;
      error_record   <= error_record_next;
      cur_pos        <= cur_pos_next;
      tgt_pos        <= tgt_pos_next;
      start_pos      <= start_pos_next;
      start_hw_count <= start_hw_count_next;
      dir_negative   <= dir_negative_next;
      saved_speed    <= saved_speed_next;
      start_time     <= start_time_next;
    end
  end

  a_enable_matches_state: assert property (@(posedge clk) disable iff (rst)
    enabled_flag == (mode_state != sams_pkg::ST_DISABLED))
    else $error("enable flag disagrees with axis state");

  a_error_has_fault: assert property (@(posedge clk) disable iff (rst)
    (mode_state == sams_pkg::ST_ERROR) |-> fault_latch)
    else $error("error state without latched fault");

  a_start_enters_moving: assert property (@(posedge clk) disable iff (rst)
    (step && result.start_move) |=> (mode_state == sams_pkg::ST_MOVING))
    else $error("started move did not enter moving");

  a_start_magnitude: assert property (@(posedge clk) disable iff (rst)
    (step && result.start_move) |-> (result.move_magnitude != '0) && !fault_latch)
    else $error("move started with zero magnitude or latched fault");

endmodule

// ===== design/stepper_axis_move_supervisor.sv =====
// Single-axis open-loop stepper supervisor.
// req: one transaction per event (tick, relative or absolute move, stop, enable,
//   disable, clear fault). A tick carries the millisecond time, the driver's
//   executed-step counter and its busy flag.
// res: exactly one transaction per accepted event, in order, carrying the status,
//   tracked position, target and the start/stop/enable commands for the driver.
// cfg: register writes (index 0 speed limit, index 1 timeout_limit), always ready;
//   write only while no event is in flight.
// A result is offered once its event has passed through the input register and then
//   the result register.
// Throughput: one event per cycle while res is not stalled; every event's state update
//   is one pass of compares and 32-bit adds between the input and result registers.
// When res stalls, the input register still takes one event; ready on req then
//   drops until the result is taken.
// Reset: synchronous; the axis comes up disabled at position zero, no fault,
//   speed limit 20000 and timeout_limit 10000, with both channels empty.
module stepper_axis_move_supervisor (
  input  logic clk,
  input  logic rst,
  sams_req_if.sink   req,
  sams_res_if.source res,
  sams_cfg_if.sink   cfg
);

  logic [sams_pkg::SPEED_W-1:0] speed_limit;
  logic [sams_pkg::TIME_W-1:0]  timeout_limit;

  logic              inq_valid;
  sams_pkg::item_t   inq;
  logic              res_valid;
  sams_pkg::result_t res_data;
  sams_pkg::result_t core_res;
  logic              adv;
  logic              step;

  assign adv       = !res_valid || res.ready;
  assign step      = inq_valid && adv;
  assign req.ready = !inq_valid || adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit   <= sams_pkg::SPEED_LIMIT_RST;
      timeout_limit <= sams_pkg::TIMEOUT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sams_pkg::CFG_SPEED_LIMIT: speed_limit   <= cfg.data[sams_pkg::SPEED_W-1:0];
        sams_pkg::CFG_TIMEOUT:     timeout_limit <= cfg.data[sams_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (req.ready) begin
      inq_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      inq.req_type      <= req.req_type;
      inq.step_amount   <= req.step_amount;
      inq.speed         <= req.speed;
      inq.now_ms        <= req.now_ms;
      inq.hw_step_count <= req.hw_step_count;
      inq.driver_busy   <= req.driver_busy;
    end
  end

  sams_axis_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (inq),
    .speed_limit   (speed_limit),
    .timeout_limit (timeout_limit),
    .result        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= inq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= core_res;
    end
  end

  assign res.valid           = res_valid;
  assign res.result_code     = res_data.result_code;
  assign res.axis_state      = res_data.axis_state;
  assign res.position        = res_data.position;
  assign res.target_position = res_data.target_position;
  assign res.fault_flag      = res_data.fault_flag;
  assign res.err_timeout     = res_data.err_timeout;
  assign res.start_move      = res_data.start_move;
  assign res.move_ccw        = res_data.move_ccw;
  assign res.move_magnitude  = res_data.move_magnitude;
  assign res.move_speed      = res_data.move_speed;
  assign res.stop_request    = res_data.stop_request;
  assign res.driver_on       = res_data.driver_on;

endmodule
